// ===== rtl/hmc_pkg.sv =====
// ---------------------------------------------------------------------------
// hmc_pkg: shared types and functions for the Hamming(7,4) stream codec
// Holds the codec state and result bundle types plus codeword helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package hmc_pkg;

  localparam logic [7:0] NIB_MASK = 8'h0F;

  // Decode and encode leave at most seven pending bits between words.
  typedef struct packed {
    logic [6:0] acc;
    logic [2:0] cnt;
    logic [3:0] held;
    logic       held_v;
  } hmc_state_t;

  // Up to three result bytes per input word, byte 0 goes out first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } hmc_res_t;

  // Codeword layout from MSB: p1 p2 d1 p3 d2 d3 d4.
  function automatic logic [6:0] make_codeword(input logic [3:0] nib);
    logic d1, d2, d3, d4;
    d1 = nib[3];
    d2 = nib[2];
    d3 = nib[1];
    d4 = nib[0];
    return {d1 ^ d2 ^ d4, d1 ^ d3 ^ d4, d1, d2 ^ d3 ^ d4, d2, d3, d4};
  endfunction

  // Position k of the codeword (1..7) sits at bit 7-k.
  function automatic logic [3:0] fix_codeword(input logic [6:0] cw);
    logic [2:0] syn;
    logic [6:0] flip;
    logic [6:0] fixed;
    syn[0] = cw[6] ^ cw[4] ^ cw[2] ^ cw[0];
    syn[1] = cw[5] ^ cw[4] ^ cw[1] ^ cw[0];
    syn[2] = cw[3] ^ cw[2] ^ cw[1] ^ cw[0];
    flip   = (syn != 3'd0) ? (7'd1 << (3'd7 - syn)) : 7'd0;
    fixed  = cw ^ flip;
    return {fixed[4], fixed[2], fixed[1], fixed[0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hamming74_stream_codec.sv =====
// ---------------------------------------------------------------------------
// hamming74_stream_codec: byte-stream Hamming(7,4) encoder and decoder
// Registers each input word, runs one codec step and queues its results.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_tvalid/in_tready with the byte in in_tdata and
//   the end of the stream on in_tlast. Results leave on out_tvalid/out_tready;
//   out_tlast marks the final byte caused by one input word.
//   cfg_wr_en/cfg_wr_data select encode (0) or decode (1) while the block is
//   idle; the pending bits carry across a mode change.
//   A word passes through the input register and then the result register.
//   Throughput: one input word per cycle when its results fit; the result
//   register sends one byte per cycle while out_tready is high, so encode,
//   with more result bytes per word, runs slower than decode.
//   A decode word can produce no result at all; it still loads the result register.
//   When the receiver stalls, the result register holds its bytes and the
//   input register holds one word, after which in_tready drops.
//   Reset clears the mode to encode and empties all pending state.
// ---------------------------------------------------------------------------
`default_nettype none

module hamming74_stream_codec (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,  // decode_mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // data_byte[7:0]
  input  wire logic       in_tlast,     // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // out_byte[7:0]
  output logic            out_tlast     // out_last
);

  logic                decode_mode_r;
  logic                in_valid_r;
  logic                in_valid_nxt;
  logic [7:0]          in_data_r;
  logic                in_last_r;
  hmc_pkg::hmc_state_t st_r;
  hmc_pkg::hmc_state_t st_nxt;
  hmc_pkg::hmc_res_t   res;
  logic                can_load;
  logic                consume;

  hmc_step u_step (
    .decode_mode (decode_mode_r),
    .data_byte   (in_data_r),
    .last_byte   (in_last_r),
    .st          (st_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  hmc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .load_res   (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    consume      = in_valid_r && can_load;
    in_tready    = !in_valid_r || can_load;
    in_valid_nxt = in_tvalid || (in_valid_r && !can_load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      in_valid_r    <= 1'b0;
      st_r          <= '0;
    end else begin
      if (cfg_wr_en) begin
        decode_mode_r <= cfg_wr_data;
      end
      in_valid_r <= in_valid_nxt;
      if (consume) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hmc_step.sv =====
// ---------------------------------------------------------------------------
// hmc_step: one-word codec step
// Combines the pending state with one input byte and produces the result
// bytes and the state that follows, for either encode or decode.
// ---------------------------------------------------------------------------
`default_nettype none

module hmc_step (
  input  wire logic              decode_mode,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire hmc_pkg::hmc_state_t st,
  output hmc_pkg::hmc_state_t    st_nxt,
  output hmc_pkg::hmc_res_t      res
);

  // Encode path
  logic [13:0] enc_code;
  logic [20:0] enc_acc;
  logic [4:0]  enc_cnt;
  logic [20:0] enc_align;
  logic        enc_two;
  logic [2:0]  enc_rem;
  logic [7:0]  enc_flush;
  logic        enc_fl;

  // Decode path
  logic [14:0] dec_acc;
  logic [4:0]  dec_cnt;
  logic [14:0] dec_align;
  logic        dec_two;
  logic [2:0]  dec_rem;
  logic [3:0]  nib1;
  logic [3:0]  nib2;
  logic [7:0]  dec_byte;
  logic        dec_emit;
  logic        dec_hv;
  logic [3:0]  dec_held;
  logic        dec_fl;
  logic [7:0]  dec_flush;

  always_comb begin
    enc_code  = {hmc_pkg::make_codeword(data_byte[7:4]),
                 hmc_pkg::make_codeword(4'(data_byte & hmc_pkg::NIB_MASK))};
    enc_acc   = {st.acc, enc_code};
    enc_cnt   = 5'({2'b00, st.cnt}) + 5'd14;
    // Left-align the valid bits so the output bytes sit at fixed places.
    enc_align = enc_acc << (5'd21 - enc_cnt);
    enc_two   = enc_cnt >= 5'd16;
    enc_rem   = enc_two ? 3'(enc_cnt - 5'd16) : 3'(enc_cnt - 5'd8);
    enc_flush = enc_two ? {enc_align[4:0], 3'b000} : enc_align[12:5];
    enc_fl    = last_byte && (enc_rem != 3'd0);

    dec_acc   = {st.acc, data_byte};
    dec_cnt   = 5'({2'b00, st.cnt}) + 5'd8;
    dec_align = dec_acc << (5'd15 - dec_cnt);
    dec_two   = dec_cnt >= 5'd14;
    dec_rem   = dec_two ? 3'(dec_cnt - 5'd14) : 3'(dec_cnt - 5'd7);
    nib1      = hmc_pkg::fix_codeword(dec_align[14:8]);
    nib2      = hmc_pkg::fix_codeword(dec_align[7:1]);
    dec_emit  = st.held_v || dec_two;
    dec_byte  = st.held_v ? {st.held, nib1} : {nib1, nib2};
    // A nibble stays held when the codeword count and the old hold agree.
    dec_hv    = (st.held_v == dec_two);
    dec_held  = st.held_v ? nib2 : nib1;
    dec_fl    = last_byte && dec_hv;
    dec_flush = {dec_held, 4'b0000};

    st_nxt = st;
    res    = '0;
    if (decode_mode) begin
      st_nxt.acc    = 7'(dec_acc) & ~(7'h7F << dec_rem);
      st_nxt.cnt    = dec_rem;
      st_nxt.held   = dec_hv ? dec_held : 4'd0;
      st_nxt.held_v = dec_hv;
      res.bytes[0]  = dec_emit ? dec_byte : dec_flush;
      res.bytes[1]  = dec_flush;
      res.bytes[2]  = 8'd0;
      res.cnt       = 2'({1'b0, dec_emit}) + 2'({1'b0, dec_fl});
    end else begin
      st_nxt.acc    = 7'(enc_acc) & ~(7'h7F << enc_rem);
      st_nxt.cnt    = enc_rem;
      res.bytes[0]  = enc_align[20:13];
      res.bytes[1]  = enc_two ? enc_align[12:5] : enc_flush;
      res.bytes[2]  = enc_flush;
      res.cnt       = (enc_two ? 2'd2 : 2'd1) + 2'({1'b0, enc_fl});
    end
    if (last_byte) begin
      st_nxt = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hmc_outbuf.sv =====
// ---------------------------------------------------------------------------
// hmc_outbuf: result register for the codec
// Holds the up to three bytes of one input word and sends them in order.
// ---------------------------------------------------------------------------
`default_nettype none

module hmc_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire hmc_pkg::hmc_res_t   load_res,
  output logic                     can_load,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,  // out_byte[7:0]
  output logic                     out_tlast   // out_last
);

  logic [2:0][7:0] byte_r;
  logic [2:0][7:0] byte_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic            pop;

  always_comb begin
    pop        = (cnt_r != 2'd0) && out_tready;
    // The buffer takes a new set when it is empty or sends its last byte now.
    can_load   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
    out_tvalid = cnt_r != 2'd0;
    out_tlast  = cnt_r == 2'd1;
    out_tdata  = byte_r[0];
    cnt_nxt    = cnt_r;
    byte_nxt   = byte_r;
    if (load) begin
      cnt_nxt  = load_res.cnt;
      byte_nxt = load_res.bytes;
    end else if (pop) begin
      cnt_nxt  = cnt_r - 2'd1;
      byte_nxt = {8'd0, byte_r[2], byte_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire
